// ===== rtl/svpwm_pkg.sv =====
// shared types and constants for the space-vector duty generator
// used by svpwm_ctrl, svpwm_dp and svpwm_sector_duty_gen; no dependencies
package svpwm_pkg;

    localparam int PERIOD_W   = 13;
    localparam int DUTY_W     = 13;
    localparam int IQ_W       = 16;
    localparam int TIME_W     = 16;
    localparam int PROD_W     = 33;
    localparam int MOP_W      = 20;
    localparam int Q_SHIFT    = 15;
    localparam int PRE_SHIFT  = 11;
    localparam int POST_SHIFT = 19;
    localparam int DIV_STEPS  = 13;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [PERIOD_W-1:0]   PERIOD_RESET  = 13'd2000;
    localparam logic signed [IQ_W-1:0] INV_SQRT3_Q15 = 16'sd18919;

    typedef enum logic [2:0] {
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5,
        SECTOR_6 = 3'd6
    } t_sector;

    typedef struct packed {
        logic load;
        logic calc_ab;
        logic calc_x;
        logic mul_ta;
        logic mul_tb;
        logic check;
        logic div_load_a;
        logic div_load_b;
        logic div_step;
        logic div_store_a;
        logic div_store_b;
        logic result;
    } t_dp_cmd;

    typedef struct packed {
        logic over;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/svpwm_ctrl.sv =====
// sequencing state machine for the duty generator
// depends on svpwm_pkg for the command and status structs
module svpwm_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  svpwm_pkg::t_dp_status   i_status,
    output svpwm_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AB,
        S_X,
        S_MTA,
        S_MTB,
        S_CHK,
        S_DLA,
        S_DA,
        S_SA,
        S_DLB,
        S_DB,
        S_SB,
        S_DUTY
    } t_state;

    t_state r_state, n_state;
    logic [svpwm_pkg::DIV_CNT_W-1:0] r_step, n_step;
    logic w_last;

    assign w_last     = (r_step == svpwm_pkg::DIV_CNT_W'(svpwm_pkg::DIV_STEPS - 1));
    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_AB;
                end
            end
            S_AB: begin
                o_cmd.calc_ab = 1'b1;
                n_state       = S_X;
            end
            S_X: begin
                o_cmd.calc_x = 1'b1;
                n_state      = S_MTA;
            end
            S_MTA: begin
                o_cmd.mul_ta = 1'b1;
                n_state      = S_MTB;
            end
            S_MTB: begin
                o_cmd.mul_tb = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.over ? S_DLA : S_DUTY;
            end
            S_DLA: begin
                o_cmd.div_load_a = 1'b1;
                n_step           = '0;
                n_state          = S_DA;
            end
            S_DA: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (w_last) begin
                    n_state = S_SA;
                end
            end
            S_SA: begin
                o_cmd.div_store_a = 1'b1;
                n_state           = S_DLB;
            end
            S_DLB: begin
                o_cmd.div_load_b = 1'b1;
                n_step           = '0;
                n_state          = S_DB;
            end
            S_DB: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (w_last) begin
                    n_state = S_SB;
                end
            end
            S_SB: begin
                o_cmd.div_store_b = 1'b1;
                n_state           = S_DUTY;
            end
            S_DUTY: begin
                // hold here while the previous result still waits at the output
                if (i_status.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== rtl/svpwm_dp.sv =====
// datapath: sector decode, shared multiplier, restoring divider, duty build
// depends on svpwm_pkg for widths, constants and the command/status structs
module svpwm_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  svpwm_pkg::t_dp_cmd                     i_cmd,
    output svpwm_pkg::t_dp_status                  o_status,
    input  logic        [svpwm_pkg::PERIOD_W-1:0]  i_period,
    input  logic signed [svpwm_pkg::IQ_W-1:0]      i_alpha,
    input  logic signed [svpwm_pkg::IQ_W-1:0]      i_beta,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic        [svpwm_pkg::DUTY_W-1:0]    o_duty_a,
    output logic        [svpwm_pkg::DUTY_W-1:0]    o_duty_b,
    output logic        [svpwm_pkg::DUTY_W-1:0]    o_duty_c,
    output logic        [2:0]                      o_sector,
    output logic                                   o_overmodulated,
    output logic        [31:0]                     o_overmod_total
);

    localparam int PW = svpwm_pkg::PROD_W;
    localparam int TW = svpwm_pkg::TIME_W;
    localparam int DW = svpwm_pkg::DUTY_W;
    localparam int NS = svpwm_pkg::DIV_STEPS;

    logic signed [15:0] r_alpha, r_beta;
    logic signed [31:0] r_a, r_b1;
    logic signed [32:0] r_xa, r_xb;
    svpwm_pkg::t_sector r_sector;
    logic [TW-1:0]      r_ta, r_tb;
    logic [TW:0]        r_sum;
    logic               r_over;
    logic [TW-1:0]      r_rem;
    logic [NS-1:0]      r_quo;
    logic [31:0]        r_cnt;
    logic               r_out_valid;
    logic [DW-1:0]      r_duty_a, r_duty_b, r_duty_c;
    svpwm_pkg::t_sector r_sec_out;
    logic               r_over_out;
    logic [31:0]        r_total;

    logic signed [32:0] w_a, w_b1, w_b2, w_nb1;
    svpwm_pkg::t_sector w_sector;
    logic signed [32:0] w_xa, w_xb;
    logic [svpwm_pkg::MOP_W-1:0] w_op;
    logic [PW-1:0]      w_prod;
    logic [TW:0]        w_sum;
    logic               w_over;
    logic [TW:0]        w_trial;
    logic               w_ge;
    logic [TW:0]        w_hi_full;
    logic [DW-1:0]      w_hi, w_mid, w_lo;
    logic [DW-1:0]      w_da, w_db, w_dc;

    // sector and active-vector expressions in Q30
    assign w_a   = {r_a[31], r_a};
    assign w_b1  = {r_b1[31], r_b1};
    assign w_b2  = {r_b1, 1'b0};
    assign w_nb1 = -w_b1;

    always_comb begin
        if (!r_beta[15]) begin
            if (!r_alpha[15]) begin
                w_sector = (w_b1 >= w_a) ? svpwm_pkg::SECTOR_2 : svpwm_pkg::SECTOR_1;
            end else begin
                w_sector = (w_nb1 >= w_a) ? svpwm_pkg::SECTOR_3 : svpwm_pkg::SECTOR_2;
            end
        end else begin
            if (!r_alpha[15]) begin
                w_sector = (w_nb1 >= w_a) ? svpwm_pkg::SECTOR_5 : svpwm_pkg::SECTOR_6;
            end else begin
                w_sector = (w_b1 >= w_a) ? svpwm_pkg::SECTOR_4 : svpwm_pkg::SECTOR_5;
            end
        end
    end

    always_comb begin
        case (w_sector)
            svpwm_pkg::SECTOR_1: begin w_xa = w_a - w_b1;  w_xb = w_b2;        end
            svpwm_pkg::SECTOR_2: begin w_xa = w_b1 - w_a;  w_xb = w_a + w_b1;  end
            svpwm_pkg::SECTOR_3: begin w_xa = w_b2;        w_xb = w_nb1 - w_a; end
            svpwm_pkg::SECTOR_4: begin w_xa = -w_b2;       w_xb = w_b1 - w_a;  end
            svpwm_pkg::SECTOR_5: begin w_xa = w_nb1 - w_a; w_xb = w_a - w_b1;  end
            default:             begin w_xa = w_a + w_b1;  w_xb = -w_b2;       end
        endcase
    end

    // one shared multiplier: active times, then rescale numerators
    always_comb begin
        w_op = '0;
        if (i_cmd.mul_ta) begin
            w_op = r_xa[32] ? '0 : r_xa[30:svpwm_pkg::PRE_SHIFT];
        end else if (i_cmd.mul_tb) begin
            w_op = r_xb[32] ? '0 : r_xb[30:svpwm_pkg::PRE_SHIFT];
        end else if (i_cmd.div_load_a) begin
            w_op = {4'd0, r_ta};
        end else if (i_cmd.div_load_b) begin
            w_op = {4'd0, r_tb};
        end
    end

    assign w_prod = PW'(w_op) * PW'(i_period);

    assign w_sum  = {1'b0, r_ta} + {1'b0, r_tb};
    assign w_over = (w_sum > {4'd0, i_period});

    // restoring divide step; remainder stays below the sum
    assign w_trial = {r_rem, r_quo[NS-1]};
    assign w_ge    = (w_trial >= r_sum);

    // centred compare values, modulo the duty width
    assign w_hi_full = {4'd0, i_period} + {1'b0, r_ta} + {1'b0, r_tb};
    assign w_hi      = w_hi_full[DW:1];
    assign w_mid     = w_hi - r_ta[DW-1:0];
    assign w_lo      = w_mid - r_tb[DW-1:0];

    always_comb begin
        case (r_sector)
            svpwm_pkg::SECTOR_1: begin w_da = w_hi;  w_db = w_mid; w_dc = w_lo;  end
            svpwm_pkg::SECTOR_2: begin w_da = w_mid; w_db = w_hi;  w_dc = w_lo;  end
            svpwm_pkg::SECTOR_3: begin w_da = w_lo;  w_db = w_hi;  w_dc = w_mid; end
            svpwm_pkg::SECTOR_4: begin w_da = w_lo;  w_db = w_mid; w_dc = w_hi;  end
            svpwm_pkg::SECTOR_5: begin w_da = w_mid; w_db = w_lo;  w_dc = w_hi;  end
            default:             begin w_da = w_hi;  w_db = w_lo;  w_dc = w_mid; end
        endcase
    end

    assign o_status.over     = w_over;
    assign o_status.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_alpha <= i_alpha;
            r_beta  <= i_beta;
        end
        if (i_cmd.calc_ab) begin
            r_a  <= {r_alpha[15], r_alpha, svpwm_pkg::Q_SHIFT'(0)};
            r_b1 <= r_beta * svpwm_pkg::INV_SQRT3_Q15;
        end
        if (i_cmd.calc_x) begin
            r_xa     <= w_xa;
            r_xb     <= w_xb;
            r_sector <= w_sector;
        end
        if (i_cmd.mul_ta) begin
            r_ta <= {2'd0, w_prod[PW-1:svpwm_pkg::POST_SHIFT]};
        end
        if (i_cmd.mul_tb) begin
            r_tb <= {2'd0, w_prod[PW-1:svpwm_pkg::POST_SHIFT]};
        end
        if (i_cmd.check) begin
            r_sum  <= w_sum;
            r_over <= w_over;
        end
        if (i_cmd.div_load_a || i_cmd.div_load_b) begin
            r_rem <= w_prod[NS+TW-1:NS];
            r_quo <= w_prod[NS-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? TW'(w_trial - r_sum) : w_trial[TW-1:0];
            r_quo <= {r_quo[NS-2:0], w_ge};
        end
        if (i_cmd.div_store_a) begin
            r_ta <= {3'd0, r_quo};
        end
        if (i_cmd.div_store_b) begin
            r_tb <= {3'd0, r_quo};
        end
        if (i_cmd.result) begin
            r_duty_a   <= w_da;
            r_duty_b   <= w_db;
            r_duty_c   <= w_dc;
            r_sec_out  <= r_sector;
            r_over_out <= r_over;
            r_total    <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.check && w_over && (r_cnt != '1)) begin
                r_cnt <= r_cnt + 32'd1;
            end
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_duty_a        = r_duty_a;
    assign o_duty_b        = r_duty_b;
    assign o_duty_c        = r_duty_c;
    assign o_sector        = r_sec_out;
    assign o_overmodulated = r_over_out;
    assign o_overmod_total = r_total;

endmodule

// ===== rtl/svpwm_sector_duty_gen.sv =====
// top level of the six-sector space-vector duty generator
// instantiates svpwm_ctrl and svpwm_dp, holds the period register; uses svpwm_pkg
//
// usage
//   input channel: i_valid / o_ready carry one Q15 alpha/beta vector per transaction
//   output channel: o_valid / i_ready carry the three phase compare values, the
//     sector, the overmodulation flag and the running overmodulation count
//   config: i_cfg_we writes i_cfg_data into the pwm period at the clock edge; the
//     user must write it only while the block is idle, the block does not enforce it
// sequencing
//   a vector in the linear range passes the calc, multiply, check and result states
//   an overmodulated vector adds the rescale: two 13-step restoring divisions
//     on one shared divider plus their load and store states, before o_valid rises
//   one vector is in work at a time; a new vector is taken only after the
//     previous one has reached the output register
// reset
//   period returns to 2000, the overmodulation count clears, both channels idle
// stall
//   the result sits in an output register; a new vector is taken while it
//   waits, and that vector stops before its own result until the register frees
module svpwm_sector_duty_gen (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [svpwm_pkg::IQ_W-1:0]     i_alpha,
    input  logic signed [svpwm_pkg::IQ_W-1:0]     i_beta,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic        [svpwm_pkg::DUTY_W-1:0]   o_duty_a,
    output logic        [svpwm_pkg::DUTY_W-1:0]   o_duty_b,
    output logic        [svpwm_pkg::DUTY_W-1:0]   o_duty_c,
    output logic        [2:0]                     o_sector,
    output logic                                  o_overmodulated,
    output logic        [31:0]                    o_overmod_total,
    input  logic                                  i_cfg_we,
    input  logic        [svpwm_pkg::PERIOD_W-1:0] i_cfg_data
);

    // carrier period, full-scale compare value
    logic [svpwm_pkg::PERIOD_W-1:0] r_period;

    svpwm_pkg::t_dp_cmd    w_cmd;
    svpwm_pkg::t_dp_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= svpwm_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_data;
        end
    end

    // sequencer: accepts a vector only in its idle state
    svpwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // arithmetic and output register
    svpwm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_period        (r_period),
        .i_alpha         (i_alpha),
        .i_beta          (i_beta),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_duty_a        (o_duty_a),
        .o_duty_b        (o_duty_b),
        .o_duty_c        (o_duty_c),
        .o_sector        (o_sector),
        .o_overmodulated (o_overmodulated),
        .o_overmod_total (o_overmod_total)
    );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for svpwm_sector_duty_gen: directed and random alpha/beta vectors
// predicts sector, compare values and the overmodulation count; depends on svpwm_pkg and the rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IQ_W       = svpwm_pkg::IQ_W;
    localparam int DUTY_W     = svpwm_pkg::DUTY_W;
    localparam int PERIOD_W   = svpwm_pkg::PERIOD_W;
    localparam int Q_SHIFT    = svpwm_pkg::Q_SHIFT;
    localparam int PRE_SHIFT  = svpwm_pkg::PRE_SHIFT;
    localparam int POST_SHIFT = svpwm_pkg::POST_SHIFT;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = svpwm_pkg::PERIOD_RESET;

    // q15 scale factors used by the sector split and the active times
    localparam longint INV_SQRT3     = 18919;
    localparam longint TWO_INV_SQRT3 = 37838;

    // pause past the longest rescale before config writes
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // one expected output transaction plus the vector that caused it
    typedef struct packed {
        logic signed [IQ_W-1:0] alpha;
        logic signed [IQ_W-1:0] beta;
        logic [DUTY_W-1:0]      duty_a;
        logic [DUTY_W-1:0]      duty_b;
        logic [DUTY_W-1:0]      duty_c;
        svpwm_pkg::t_sector     sector;
        logic                   over;
        logic [31:0]            total;
    } t_duty_set;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic signed [IQ_W-1:0] i_alpha;
    logic signed [IQ_W-1:0] i_beta;
    logic                   o_valid;
    logic                   i_ready;
    logic [DUTY_W-1:0]      o_duty_a;
    logic [DUTY_W-1:0]      o_duty_b;
    logic [DUTY_W-1:0]      o_duty_c;
    logic [2:0]             o_sector;
    logic                   o_overmodulated;
    logic [31:0]            o_overmod_total;
    logic                   i_cfg_we;
    logic [PERIOD_W-1:0]    i_cfg_data;

    // predictor state: the period register and the saturating overmod count
    logic [PERIOD_W-1:0] period_model;
    logic [31:0]         overmod_model;

    t_duty_set expected_duties[$];
    int        mismatch_count;

    // idle percentages, changed per traffic phase
    int send_idle_pct;
    int recv_idle_pct;

    svpwm_sector_duty_gen dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_alpha         (i_alpha),
        .i_beta          (i_beta),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_duty_a        (o_duty_a),
        .o_duty_b        (o_duty_b),
        .o_duty_c        (o_duty_c),
        .o_sector        (o_sector),
        .o_overmodulated (o_overmodulated),
        .o_overmod_total (o_overmod_total),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the handshake hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // active time from a q30 expression, clamped at zero for negative input
    function automatic longint unsigned active_time(input longint x, input longint unsigned p);
        if (x < 0)
            return 0;
        return ((unsigned'(x) >> PRE_SHIFT) * p) >> POST_SHIFT;
    endfunction

    // sector, active times, optional rescale and the three centred compare values
    function automatic t_duty_set compute_duties(input logic signed [IQ_W-1:0] al,
                                                 input logic signed [IQ_W-1:0] be,
                                                 input logic [PERIOD_W-1:0] per,
                                                 input logic [31:0] cnt);
        longint             sa, sb, a, b1, b2, xa, xb;
        longint unsigned    p, ta, tb, sum, hi, mid, lo;
        longint unsigned    duty [3];
        int                 hi_ph, mid_ph, lo_ph;
        svpwm_pkg::t_sector sec;
        logic               over;
        t_duty_set          r;
        sa = longint'(al);
        sb = longint'(be);
        a  = sa <<< Q_SHIFT;
        b1 = INV_SQRT3 * sb;
        b2 = TWO_INV_SQRT3 * sb;
        p  = longint'(per);

        // ties go to the higher-numbered sector of each pair for beta >= 0, to the lower one for beta < 0
        if (sb >= 0) begin
            if (sa >= 0)
                sec = (b1 >= a) ? svpwm_pkg::SECTOR_2 : svpwm_pkg::SECTOR_1;
            else
                sec = (-b1 >= a) ? svpwm_pkg::SECTOR_3 : svpwm_pkg::SECTOR_2;
        end else begin
            if (sa >= 0)
                sec = (-b1 >= a) ? svpwm_pkg::SECTOR_5 : svpwm_pkg::SECTOR_6;
            else
                sec = (b1 >= a) ? svpwm_pkg::SECTOR_4 : svpwm_pkg::SECTOR_5;
        end

        // xa comes off the leading phase first, then xb
        case (sec)
            svpwm_pkg::SECTOR_1: begin
                xa = a - b1;  xb = b2;      hi_ph = 0; mid_ph = 1; lo_ph = 2;
            end
            svpwm_pkg::SECTOR_2: begin
                xa = -a + b1; xb = a + b1;  hi_ph = 1; mid_ph = 0; lo_ph = 2;
            end
            svpwm_pkg::SECTOR_3: begin
                xa = b2;      xb = -a - b1; hi_ph = 1; mid_ph = 2; lo_ph = 0;
            end
            svpwm_pkg::SECTOR_4: begin
                xa = -b2;     xb = -a + b1; hi_ph = 2; mid_ph = 1; lo_ph = 0;
            end
            svpwm_pkg::SECTOR_5: begin
                xa = -a - b1; xb = a - b1;  hi_ph = 2; mid_ph = 0; lo_ph = 1;
            end
            default: begin
                xa = a + b1;  xb = -b2;     hi_ph = 0; mid_ph = 2; lo_ph = 1;
            end
        endcase

        ta   = active_time(xa, p);
        tb   = active_time(xb, p);
        sum  = ta + tb;
        over = 1'b0;
        // overmodulation: shrink both times so they fit the period
        if (sum > p) begin
            ta   = ta * p / sum;
            tb   = tb * p / sum;
            over = 1'b1;
        end

        hi  = (p + ta + tb) >> 1;
        mid = hi - ta;
        lo  = mid - tb;
        duty[hi_ph]  = hi;
        duty[mid_ph] = mid;
        duty[lo_ph]  = lo;

        r.alpha  = al;
        r.beta   = be;
        r.duty_a = DUTY_W'(duty[0]);
        r.duty_b = DUTY_W'(duty[1]);
        r.duty_c = DUTY_W'(duty[2]);
        r.sector = sec;
        r.over   = over;
        // counter holds at full scale
        r.total  = (over && cnt != 32'hFFFF_FFFF) ? cnt + 32'd1 : cnt;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // one input transaction: optional idle gap, then hold valid until accepted
    task automatic send_vector(input int al, input int be);
        t_duty_set r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_alpha <= IQ_W'(al);
        i_beta  <= IQ_W'(be);
        do @(posedge i_clk); while (!o_ready);
        // accepted at this edge, predict with the period in force now
        r = compute_duties(IQ_W'(al), IQ_W'(be), period_model, overmod_model);
        overmod_model = r.total;
        expected_duties.push_back(r);
    endtask

    // drop valid and let every outstanding result drain, then settle
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (expected_duties.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // period register write, only with the block idle
    task automatic set_period(input logic [PERIOD_W-1:0] p);
        wait_results_done();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= p;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        period_model = p;
    endtask

    // random vector: full range, linear-range, or near a sector boundary
    task automatic pick_vector(output int al, output int be);
        int kind;
        kind = $urandom_range(9);
        if (kind < 5) begin
            al = int'($signed(IQ_W'($urandom)));
            be = int'($signed(IQ_W'($urandom)));
        end else if (kind < 8) begin
            al = int'($urandom_range(44000)) - 22000;
            be = int'($urandom_range(44000)) - 22000;
        end else begin
            al = 18918 + int'($urandom_range(2));
            if ($urandom_range(1))
                al = -al;
            be = $urandom_range(1) ? -32768 : -32767 + int'($urandom_range(3));
            if ($urandom_range(3) == 0) begin
                al = $urandom_range(1) ? 0 : al;
                be = $urandom_range(1) ? 0 : be;
            end
        end
    endtask

    // zero vector, field extremes, one vector per sector, both tie cases
    task automatic test_directed_vectors();
        set_period(PERIOD_RESET);
        send_vector(0, 0);
        send_vector(32767, 0);
        send_vector(-32768, 0);
        send_vector(0, 32767);
        send_vector(0, -32768);
        send_vector(16384, 16384);
        send_vector(8000, 30000);
        send_vector(-30000, 8000);
        send_vector(-30000, -8000);
        send_vector(-8000, -30000);
        send_vector(30000, -8000);
        send_vector(-18919, -32768);
        send_vector(18919, -32768);
        send_vector(32767, 32767);
        send_vector(-32768, -32768);
        send_vector(32767, -32768);
        send_vector(-32768, 32767);
        send_vector(1, 1);
        send_vector(-1, -1);
    endtask

    // periods below the legal range and at both ends of it
    task automatic test_period_extremes();
        set_period(13'd0);
        send_vector(32767, 32767);
        send_vector(0, 0);
        set_period(13'd1);
        send_vector(-32768, 20000);
        set_period(13'd2);
        send_vector(32767, -32768);
        send_vector(100, -50);
        set_period(13'd8191);
        send_vector(-32768, -32768);
        send_vector(12000, 5000);
    endtask

    // three idling phases, each with two period settings
    task automatic test_random_vectors();
        int al;
        int be;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 11; recv_idle_pct = 86; end
                1: begin send_idle_pct = 86; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int blk = 0; blk < 2; blk++) begin
                case (ph * 2 + blk)
                    0: set_period(13'd8191);
                    1: set_period(13'd2);
                    3: set_period(PERIOD_RESET);
                    default: set_period(PERIOD_W'($urandom_range(2, 8191)));
                endcase
                repeat (300) begin
                    pick_vector(al, be);
                    send_vector(al, be);
                    // occasionally hold the sender until the pipe is empty
                    if ($urandom_range(199) == 0)
                        wait_results_done();
                end
            end
        end
    endtask

    // receiver: ready toggles at random per the current phase
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // checker: compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_duty_set want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_duties.size() == 0) begin
                flag_mismatch("output transaction with nothing expected");
            end else begin
                want = expected_duties.pop_front();
                if (o_duty_a !== want.duty_a)
                    flag_mismatch($sformatf("duty_a %0d expected %0d (alpha %0d beta %0d)",
                                  o_duty_a, want.duty_a, want.alpha, want.beta));
                if (o_duty_b !== want.duty_b)
                    flag_mismatch($sformatf("duty_b %0d expected %0d (alpha %0d beta %0d)",
                                  o_duty_b, want.duty_b, want.alpha, want.beta));
                if (o_duty_c !== want.duty_c)
                    flag_mismatch($sformatf("duty_c %0d expected %0d (alpha %0d beta %0d)",
                                  o_duty_c, want.duty_c, want.alpha, want.beta));
                if (o_sector !== want.sector)
                    flag_mismatch($sformatf("sector %0d expected %0d (alpha %0d beta %0d)",
                                  o_sector, want.sector, want.alpha, want.beta));
                if (o_overmodulated !== want.over)
                    flag_mismatch($sformatf("overmodulated %0b expected %0b (alpha %0d beta %0d)",
                                  o_overmodulated, want.over, want.alpha, want.beta));
                if (o_overmod_total !== want.total)
                    flag_mismatch($sformatf("overmod_total %0d expected %0d (alpha %0d beta %0d)",
                                  o_overmod_total, want.total, want.alpha, want.beta));
            end
        end
    end

    // main sequence: reset once, then the tests in turn
    initial begin
        mismatch_count = 0;
        period_model   = PERIOD_RESET;
        overmod_model  = 32'd0;
        send_idle_pct  = 11;
        recv_idle_pct  = 86;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_alpha    <= '0;
        i_beta     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_vectors();
        test_period_extremes();
        test_random_vectors();

        wait_results_done();
        if (expected_duties.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_duties.size()));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
